>>> hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and microcode encoding of the radix converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Word and field widths
  localparam int WORD_BITS_DEF = 32;
  localparam int RADIX_W       = 6;
  localparam int CHAR_W        = 8;

  // Radix register limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // Divider retires this many quotient bits per cycle
  localparam int DIV_STEPS = 8;

  // Character codes
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A     = 8'h41;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
  localparam logic [RADIX_W-1:0] DEC_BASE    = 6'd10;

  // Microprogram addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_LOAD   = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV    = 4'd1;
  localparam logic [PC_W-1:0] PC_STORE  = 4'd2;
  localparam logic [PC_W-1:0] PC_SIGNCK = 4'd3;
  localparam logic [PC_W-1:0] PC_SIGN   = 4'd4;
  localparam logic [PC_W-1:0] PC_READ   = 4'd5;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd6;
  localparam logic [PC_W-1:0] PC_DONE   = 4'd7;

  // Datapath operation of one control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_STEP,
    OP_STORE,
    OP_EMIT_SIGN,
    OP_READ,
    OP_EMIT_DIGIT
  } op_t;

  // Hold conditions: the step repeats while the condition is true
  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_t;

  // Jump conditions, evaluated once the step is no longer held
  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_DIV_BUSY,
    J_MORE_DIGITS,
    J_NOT_NEG,
    J_MORE_CHARS
  } jump_t;

  typedef struct packed {
    op_t             op;
    wait_t           hold;
    jump_t           jump;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_full;
    logic div_busy;
    logic more_digits;
    logic neg;
    logic more_chars;
  } status_t;

  // Sequencer command to the datapath
  typedef struct packed {
    op_t  op;
    logic fire;
  } ctrl_t;

  // Map one digit to its ASCII code
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < DEC_BASE) begin
      code = ASCII_ZERO + CHAR_W'(d);
    end else begin
      code = ASCII_A + CHAR_W'(d - DEC_BASE);
    end
    return code;
  endfunction

  // Clamp a written radix into the supported range
  function automatic logic [RADIX_W-1:0] radix_sat(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] s;
    if (r < RADIX_MIN) begin
      s = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      s = RADIX_MAX;
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

>>> hdl/itoa_ucode_rom.sv
// ----------------------------------------------------------------------------
// itoa_ucode_rom
// Microprogram store: one control word per program step.
// ----------------------------------------------------------------------------
module itoa_ucode_rom (
  input  logic [itoa_pkg::PC_W-1:0] pc,
  output itoa_pkg::ucode_t          word
);
  import itoa_pkg::*;

  // Program: load, divide per digit, optional sign, then emit digits top down
  always_comb begin
    case (pc)
      PC_LOAD:   word = '{op: OP_LOAD,       hold: W_IN,   jump: J_NEVER,       target: PC_LOAD};
      PC_DIV:    word = '{op: OP_DIV_STEP,   hold: W_NONE, jump: J_DIV_BUSY,    target: PC_DIV};
      PC_STORE:  word = '{op: OP_STORE,      hold: W_NONE, jump: J_MORE_DIGITS, target: PC_DIV};
      PC_SIGNCK: word = '{op: OP_NOP,        hold: W_NONE, jump: J_NOT_NEG,     target: PC_READ};
      PC_SIGN:   word = '{op: OP_EMIT_SIGN,  hold: W_OUT,  jump: J_NEVER,       target: PC_SIGN};
      PC_READ:   word = '{op: OP_READ,       hold: W_NONE, jump: J_NEVER,       target: PC_READ};
      PC_EMIT:   word = '{op: OP_EMIT_DIGIT, hold: W_OUT,  jump: J_MORE_CHARS,  target: PC_READ};
      PC_DONE:   word = '{op: OP_NOP,        hold: W_NONE, jump: J_ALWAYS,      target: PC_LOAD};
      default:   word = '{op: OP_NOP,        hold: W_NONE, jump: J_ALWAYS,      target: PC_LOAD};
    endcase
  end

endmodule

>>> hdl/itoa_sequencer.sv
// ----------------------------------------------------------------------------
// itoa_sequencer
// Step counter with hold and conditional jump over the microprogram.
// ----------------------------------------------------------------------------
module itoa_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  itoa_pkg::status_t status,
  output itoa_pkg::ctrl_t   ctrl
);
  import itoa_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ucode_t          word;
  logic            held;
  logic            taken;

  itoa_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  // Decode hold condition
  always_comb begin
    case (word.hold)
      W_NONE:  held = 1'b0;
      W_IN:    held = !status.in_valid;
      W_OUT:   held = status.out_full;
      default: held = 1'b0;
    endcase
  end

  // Decode jump condition
  always_comb begin
    case (word.jump)
      J_NEVER:       taken = 1'b0;
      J_ALWAYS:      taken = 1'b1;
      J_DIV_BUSY:    taken = status.div_busy;
      J_MORE_DIGITS: taken = status.more_digits;
      J_NOT_NEG:     taken = !status.neg;
      J_MORE_CHARS:  taken = status.more_chars;
      default:       taken = 1'b0;
    endcase
  end

  // Hold, jump or advance
  always_comb begin
    if (held) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op   = word.op;
  assign ctrl.fire = !held;

endmodule

>>> hdl/itoa_divider.sv
// ----------------------------------------------------------------------------
// itoa_divider
// Restoring divider by the radix, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module itoa_divider #(
  parameter int WORD_BITS = itoa_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  itoa_pkg::ctrl_t              ctrl,
  input  logic [WORD_BITS-1:0]         load_value,
  input  logic [itoa_pkg::RADIX_W-1:0] radix,
  output logic [itoa_pkg::RADIX_W-1:0] rem,
  output logic                         busy,
  output logic                         quot_zero
);
  import itoa_pkg::*;

  localparam int PAD_W   = ((WORD_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CYC = PAD_W / DIV_STEPS;
  localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  logic [PAD_W-1:0]   acc_r;
  logic [PAD_W-1:0]   acc_nxt;
  logic [RADIX_W-1:0] rem_r;
  logic [RADIX_W-1:0] rem_nxt;
  logic [CYC_W-1:0]   cyc_r;
  logic [CYC_W-1:0]   cyc_nxt;
  logic [RADIX_W-1:0] step_rem;
  logic [DIV_STEPS-1:0] step_q;

  // Retire DIV_STEPS quotient bits from the top of the accumulator
  always_comb begin
    logic [RADIX_W:0] trial;
    step_rem = rem_r;
    step_q   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {step_rem, acc_r[PAD_W-1-k]};
      if (trial >= {1'b0, radix}) begin
        trial = trial - {1'b0, radix};
        step_q[DIV_STEPS-1-k] = 1'b1;
      end
      step_rem = trial[RADIX_W-1:0];
    end
  end

  // Load a word, advance the division, or restart it for the next digit
  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    cyc_nxt = cyc_r;
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_LOAD: begin
          acc_nxt = PAD_W'(load_value);
          rem_nxt = '0;
          cyc_nxt = '0;
        end
        OP_DIV_STEP: begin
          acc_nxt = (acc_r << DIV_STEPS) | PAD_W'(step_q);
          rem_nxt = step_rem;
          cyc_nxt = cyc_r + 1'b1;
        end
        OP_STORE: begin
          rem_nxt = '0;
          cyc_nxt = '0;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r <= '0;
    end else begin
      cyc_r <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign rem       = rem_r;
  assign busy      = (cyc_r != CYC_W'(DIV_CYC - 1));
  assign quot_zero = (acc_r == '0);

endmodule

>>> hdl/itoa_digit_mem.sv
// ----------------------------------------------------------------------------
// itoa_digit_mem
// Digit store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itoa_digit_mem #(
  parameter int DEPTH = itoa_pkg::WORD_BITS_DEF,
  parameter int AW    = $clog2(itoa_pkg::WORD_BITS_DEF)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [itoa_pkg::RADIX_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [itoa_pkg::RADIX_W-1:0] rdata
);
  import itoa_pkg::*;

  logic [RADIX_W-1:0] mem [DEPTH];
  logic [RADIX_W-1:0] rdata_r;

  // Write one digit
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one digit, hold the data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/integer_to_ascii_radix_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Integer to ASCII text converter in a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transaction carries a word (tdata) and a signed flag (tuser).
//   out_*  : one transaction per character, most significant digit first;
//            a negative signed word starts with '-'; tlast marks the final
//            character of the run.
//   cfg_*  : writes the radix; values below 2 act as 2, above 36 as 36.
//            Write it only while the block is idle.
// Sequence: a microprogram handles one word at a time. Each digit costs one
//   division by the radix (eight quotient bits per cycle) plus a store
//   step; each character costs a read and an emit step.
// The next word is accepted while the last character still waits in the
//   output register. A stalled receiver holds the sequencer on its emit step.
// Reset (synchronous, rst_n low) sets the radix to 10 and empties the output;
//   no input or radix transaction is taken while rst_n is low.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_top #(
  parameter int WORD_BITS = itoa_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: value [WORD_BITS-1:0], zero fill to whole bytes
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0] in_tdata,
  // in_tuser: is_signed [0]
  input  logic                         in_tuser,
  // out_tdata: char_code [7:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [itoa_pkg::CHAR_W-1:0]  out_tdata,
  output logic                         out_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [itoa_pkg::RADIX_W-1:0] cfg_data
);
  import itoa_pkg::*;

  localparam int AW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int CNT_W = $clog2(WORD_BITS + 1);

  ctrl_t              ctrl;
  status_t            status;
  logic [RADIX_W-1:0] radix_r;
  logic               neg_r;
  logic               neg_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   cnt_dec;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r;
  logic [CHAR_W-1:0]  out_char_nxt;
  logic               out_last_r;
  logic               out_last_nxt;
  logic [WORD_BITS-1:0] in_word;
  logic                 in_neg;
  logic [WORD_BITS-1:0] magnitude;
  logic [RADIX_W-1:0]   div_rem;
  logic                 div_busy;
  logic                 quot_zero;
  logic [RADIX_W-1:0]   mem_rdata;
  logic                 fire_store;
  logic                 fire_read;

  itoa_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // Take the magnitude of a negative signed word
  assign in_word   = in_tdata[WORD_BITS-1:0];
  assign in_neg    = in_tuser & in_word[WORD_BITS-1];
  assign magnitude = in_neg ? (~in_word + 1'b1) : in_word;

  itoa_divider #(
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .load_value (magnitude),
    .radix      (radix_r),
    .rem        (div_rem),
    .busy       (div_busy),
    .quot_zero  (quot_zero)
  );

  assign fire_store = ctrl.fire && (ctrl.op == OP_STORE);
  assign fire_read  = ctrl.fire && (ctrl.op == OP_READ);
  assign cnt_dec    = cnt_r - 1'b1;

  itoa_digit_mem #(
    .DEPTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (fire_store),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_rem),
    .re    (fire_read),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Flags for the sequencer
  assign status.in_valid    = in_tvalid;
  assign status.out_full    = out_valid_r && !out_tready;
  assign status.div_busy    = div_busy;
  assign status.more_digits = !quot_zero && (cnt_r != CNT_W'(WORD_BITS - 1));
  assign status.neg         = neg_r;
  assign status.more_chars  = (cnt_r != '0);

  // Radix register, saturated on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix_r <= radix_sat(cfg_data);
    end
  end
  assign cfg_ready = rst_n;

  // Digit count, sign flag and output register
  always_comb begin
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_LOAD: begin
          neg_nxt = in_neg;
          cnt_nxt = '0;
        end
        OP_STORE: begin
          cnt_nxt = cnt_r + 1'b1;
        end
        OP_EMIT_SIGN: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
        end
        OP_READ: begin
          cnt_nxt = cnt_dec;
        end
        OP_EMIT_DIGIT: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ascii_of(mem_rdata);
          out_last_nxt  = (cnt_r == '0);
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = rst_n && (ctrl.op == OP_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix integer-to-text converter.
// A directed table covers reset radix, word extremes, the minus sign, the
// most negative word and radix saturation at both ends. Random phases
// follow, each with its own radix. Every word is predicted as a character
// run and compared character by character with the output stream, under
// random idling on the input side and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int W          = WORD_BITS_DEF;
  localparam int TDATA_W    = ((W + 7) / 8) * 8;
  localparam int CYCLE_CAP  = 4000000;
  localparam int SETTLE     = 8;
  localparam int PHASE_SIZE = 45;
  localparam int PHASES     = 10;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [W-1:0]       word;
    logic               sgn;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [CHAR_W-1:0]  out_tdata;
  logic               out_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data = '0;

  // Model copy of the radix register and the characters still owed
  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  char_t              expected_chars[$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  bit                 no_gaps = 1'b0;

  row_t               rows[$];
  string              row_text[$];

  integer_to_ascii_radix_top #(.WORD_BITS(W)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value [31:0]
    .in_tuser   (in_tuser),   // is_signed [0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // char_code [7:0]
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Free-running 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int len;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(10, 40);
    end else begin
      len = $urandom_range(1, 3);
    end
    return len;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 10) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d) - 8'd10;
    end
    return c;
  endfunction

  // Predict the character run of one word under the current radix
  function automatic void predict_text(input logic [W-1:0] word, input logic sgn);
    logic [RADIX_W-1:0] base;
    logic [W-1:0]       mag;
    logic [RADIX_W-1:0] digits [W];
    logic               neg;
    int                 n;
    base = radix_reg;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    neg = sgn && word[W-1];
    mag = neg ? (~word + 1'b1) : word;
    n = 0;
    do begin
      digits[n] = RADIX_W'(mag % W'(base));
      mag = mag / W'(base);
      n++;
    end while (mag != 0 && n < W);
    if (neg) begin
      expected_chars.push_back('{ASCII_MINUS, 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      expected_chars.push_back('{digit_char(digits[i]), (i == 0)});
    end
  endfunction

  // Queue a hand-written character run
  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expected_chars.push_back('{s[i], (i == s.len() - 1)});
    end
  endfunction

  // Present one word; valid stays high unless a gap is taken
  task automatic send_word(input logic [W-1:0] word, input logic sgn, input string text);
    int gap;
    gap = (!no_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(word);
    in_tuser  <= sgn;
    do @(posedge clk); while (!in_tready);
    if (text.len() > 0) begin
      push_text(text);
    end else begin
      predict_text(word, sgn);
    end
  endtask

  // Hold the input until every owed character has left the block
  task automatic wait_for_text_done();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_reg = r;
  endtask

  function automatic void add_row(input logic [RADIX_W-1:0] r, input logic [W-1:0] word,
                                  input logic sgn, input string text);
    rows.push_back('{r, word, sgn});
    row_text.push_back(text);
  endfunction

  function automatic logic [W-1:0] pick_word();
    logic [W-1:0] w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: w = '0;
          1: w = 1;
          2: w = '1;
          3: w = {1'b1, {(W-1){1'b0}}};
          4: w = {1'b0, {(W-1){1'b1}}};
          default: w = {1'b1, {(W-2){1'b0}}, 1'b1};
        endcase
      end
      1, 2: w = W'($urandom_range(0, 1300));
      3, 4: w = W'($urandom) >> $urandom_range(0, W - 1);
      default: w = W'($urandom);
    endcase
    return w;
  endfunction

  // Back-pressure on the result side
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= gap_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest owed character
  always @(posedge clk) begin
    char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b", out_tdata,
                                  out_tlast));
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== want.code) begin
          report_mismatch($sformatf("char_code 0x%02h, want 0x%02h", out_tdata, want.code));
        end
        if (out_tlast !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b on char 0x%02h", out_tlast,
                                    want.last, want.code));
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [RADIX_W-1:0] phase_radix;

    // Directed table: radix, word, signed, text ("" = use predictor)
    add_row(6'd10, 32'h0000_0000, 1'b0, "0");
    add_row(6'd10, 32'h0000_0000, 1'b1, "0");
    add_row(6'd10, 32'hFFFF_FFFF, 1'b0, "4294967295");
    add_row(6'd10, 32'hFFFF_FFFF, 1'b1, "-1");
    add_row(6'd10, 32'h8000_0000, 1'b1, "-2147483648");
    add_row(6'd10, 32'h7FFF_FFFF, 1'b1, "2147483647");
    add_row(6'd10, 32'h8000_0000, 1'b0, "2147483648");
    add_row(6'd10, 32'd9,         1'b0, "9");
    add_row(6'd10, 32'd10,        1'b0, "10");
    add_row(6'd10, 32'd12345,     1'b1, "");
    add_row(6'd2,  32'hFFFF_FFFF, 1'b0, "");
    add_row(6'd2,  32'h8000_0000, 1'b1, "");
    add_row(6'd0,  32'd5,         1'b0, "101");
    add_row(6'd1,  32'd6,         1'b0, "110");
    add_row(6'd16, 32'hDEAD_BEEF, 1'b0, "DEADBEEF");
    add_row(6'd16, 32'hFFFF_FFFF, 1'b1, "-1");
    add_row(6'd16, 32'h8000_0000, 1'b1, "-80000000");
    add_row(6'd36, 32'd35,        1'b0, "Z");
    add_row(6'd36, 32'hFFFF_FFFF, 1'b0, "");
    add_row(6'd37, 32'd35,        1'b0, "Z");
    add_row(6'd63, 32'd36,        1'b0, "10");
    add_row(6'd8,  32'h8000_0000, 1'b1, "-20000000000");
    add_row(6'd3,  32'h0000_0000, 1'b1, "0");
    add_row(6'd3,  32'h7FFF_FFFF, 1'b0, "");

    // Hold reset, then release
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Walk the table; first rows run without idling at the reset radix
    no_gaps = 1'b1;
    foreach (rows[i]) begin
      if (i == 7) begin
        no_gaps = 1'b0;
      end
      if (rows[i].radix != radix_reg) begin
        wait_for_text_done();
        write_radix(rows[i].radix);
      end
      send_word(rows[i].word, rows[i].sgn, row_text[i]);
    end

    // Random phases, each with its own radix
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_radix = 6'd10;
        1: phase_radix = 6'd2;
        2: phase_radix = 6'd36;
        3: phase_radix = 6'd16;
        4: phase_radix = 6'd63;
        5: phase_radix = 6'd0;
        6: phase_radix = 6'd37;
        7: phase_radix = 6'd1;
        default: phase_radix = RADIX_W'($urandom_range(0, 63));
      endcase
      wait_for_text_done();
      write_radix(phase_radix);
      no_gaps = (p == 3);
      for (int k = 0; k < PHASE_SIZE; k++) begin
        // Now and then let the output run dry before the next word
        if ($urandom_range(0, 49) == 0) begin
          wait_for_text_done();
        end
        send_word(pick_word(), 1'($urandom_range(0, 1)), "");
      end
    end

    // Drain, then watch for stray characters
    in_tvalid <= 1'b0;
    no_gaps = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
